@@ src/rkc_pkg.sv @@
// shared types and constants for the registration keep-alive client
`default_nettype none
package rkc_pkg;

	localparam int TIME_W = 32;
	localparam int CFG_W = 20;
	localparam int LFSR_W = 16;
	localparam int DIV_W = CFG_W + 1;
	localparam int CNT_W = $clog2(LFSR_W);
	localparam int CIDX_W = 2;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 8;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

	localparam logic [CFG_W-1:0] REQ_INTERVAL_RST = 20'd1000;
	localparam logic [CFG_W-1:0] REQ_TIMEOUT_RST = 20'd10000;
	localparam logic [CFG_W-1:0] NOOP_MIN_RST = 20'd1000;
	localparam logic [CFG_W-1:0] NOOP_MAX_RST = 20'd3000;

	typedef enum logic [CIDX_W-1:0] {
		CFG_REQ_INTERVAL = 2'd0,
		CFG_REQ_TIMEOUT = 2'd1,
		CFG_NOOP_MIN = 2'd2,
		CFG_NOOP_MAX = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		REQ_TICK = 3'd0,
		REQ_REGISTER = 3'd1,
		REQ_UNREGISTER = 3'd2,
		REQ_SEND_DATA = 3'd3,
		REQ_REPLY = 3'd4
	} req_type_t;

	typedef enum logic [1:0] {
		RPL_REG_AGREE = 2'd0,
		RPL_REG_REFUSE = 2'd1,
		RPL_UNREG_OK = 2'd2,
		RPL_OTHER = 2'd3
	} reply_code_t;

	typedef enum logic [2:0] {
		SEND_NONE = 3'd0,
		SEND_REGISTER = 3'd1,
		SEND_UNREGISTER = 3'd2,
		SEND_KEEPALIVE = 3'd3,
		SEND_DATA = 3'd4
	} send_kind_t;

	typedef enum logic [2:0] {
		LS_IDLE = 3'd0,
		LS_REGING = 3'd1,
		LS_WORKING = 3'd2,
		LS_UNREGING = 3'd3,
		LS_ENDED = 3'd4,
		LS_DROPPED = 3'd5,
		LS_REFUSED = 3'd6
	} link_status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_LOAD,
		FSM_EVAL,
		FSM_ACT,
		FSM_MODW,
		FSM_OUT
	} fsm_state_t;

	typedef struct packed {
		logic cap_in;
		logic tick_inc;
		logic eval;
		logic st_we;
		link_status_t st_nxt;
		logic start_req;
		logic last_req_we;
		logic enter_work;
		logic draw;
		logic ivl_we;
		logic out_we;
		send_kind_t send;
		logic tout;
	} rkc_cmd_t;

	typedef struct packed {
		logic [2:0] typ;
		logic [1:0] code;
		link_status_t st;
		logic r_start;
		logic r_last;
		logic r_ka;
		logic mod_done;
		logic out_free;
	} rkc_sts_t;

endpackage
`default_nettype wire

@@ src/registration_keepalive_client_core.sv @@
// top level of the registration keep-alive client
// sequence: an accepted transaction passes the controller states load, evaluate and act,
//   waits for the bit-serial remainder unit when a keep-alive is sent (it draws the
//   keep-alive interval), then is written to the output register once that is free
// no new transaction is accepted until the previous result is in the output register
// reset: arst_n clears status, clocks and intervals, seeds the lfsr, restores config defaults
`default_nettype none
module registration_keepalive_client_core
	import rkc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // reply_code[1:0], zero pad
	input  wire logic [2:0]            s_tuser,   // req_type[2:0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // status[2:0], timed_out[3], zero pad
	output logic [2:0]                 m_tuser,   // send_kind[2:0]
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CIDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	rkc_cmd_t cmd;
	rkc_sts_t sts;

	assign cfg_ready = 1'b1;

	rkc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rkc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

@@ src/rkc_mod.sv @@
// iterative restoring remainder unit, one dividend bit per cycle
`default_nettype none
module rkc_mod
	import rkc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [LFSR_W-1:0] dividend,
	input  wire logic [DIV_W-1:0]  divisor,
	output logic                   done,
	output logic [CFG_W-1:0]       rem
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LFSR_W-1:0] dvd_q;
	logic [DIV_W-1:0]  div_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;

	assign trial = {rem_q, dvd_q[LFSR_W-1]};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(LFSR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[LFSR_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[DIV_W-1:0];
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem = rem_q[CFG_W-1:0];

endmodule
`default_nettype wire

@@ src/rkc_dp.sv @@
// datapath: configuration, time registers, elapsed-time compares, lfsr, output register
`default_nettype none
module rkc_dp
	import rkc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rkc_cmd_t              cmd,
	output rkc_sts_t                   sts,
	input  wire logic                  cfg_valid,
	input  wire logic [CIDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [2:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic [2:0]                 m_tuser
);

	logic [CFG_W-1:0]  req_interval_q, req_timeout_q, noop_min_q, noop_max_q;
	logic [2:0]        typ_q;
	logic [1:0]        code_q;
	link_status_t      status_q;
	logic [TIME_W-1:0] clock_q, req_start_q, last_req_q, last_ka_q;
	logic [CFG_W-1:0]  ka_ivl_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic              r_start_q, r_last_q, r_ka_q;
	logic              m_valid_q;
	send_kind_t        m_send_q;
	link_status_t      m_status_q;
	logic              m_tout_q;

	logic [TIME_W-1:0] d_start, d_last, d_ka;
	logic [TIME_W-1:0] req_base;
	logic [LFSR_W-1:0] lfsr_nxt;
	logic              rng_rev;
	logic [DIV_W-1:0]  span;
	logic              mod_done;
	logic [CFG_W-1:0]  mod_rem;

	assign d_start = clock_q - req_start_q;
	assign d_last = clock_q - last_req_q;
	assign d_ka = clock_q - last_ka_q;
	assign req_base = clock_q - TIME_W'(req_interval_q);
	assign lfsr_nxt = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_MASK : '0);
	assign rng_rev = noop_max_q < noop_min_q;
	assign span = {1'b0, noop_max_q} - {1'b0, noop_min_q} + DIV_W'(1);

	rkc_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.draw),
		.dividend (lfsr_nxt),
		.divisor  (span),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_interval_q <= REQ_INTERVAL_RST;
			req_timeout_q <= REQ_TIMEOUT_RST;
			noop_min_q <= NOOP_MIN_RST;
			noop_max_q <= NOOP_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_REQ_INTERVAL: req_interval_q <= cfg_data;
				CFG_REQ_TIMEOUT:  req_timeout_q <= cfg_data;
				CFG_NOOP_MIN:     noop_min_q <= cfg_data;
				CFG_NOOP_MAX:     noop_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= LS_IDLE;
			clock_q <= '0;
			req_start_q <= '0;
			last_req_q <= '0;
			last_ka_q <= '0;
			ka_ivl_q <= '0;
			lfsr_q <= LFSR_SEED;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.tick_inc) begin
				clock_q <= clock_q + TIME_W'(1);
			end
			if (cmd.st_we) begin
				status_q <= cmd.st_nxt;
			end
			if (cmd.start_req) begin
				req_start_q <= req_base;
				last_req_q <= req_base;
			end else if (cmd.last_req_we) begin
				last_req_q <= clock_q;
			end
			if (cmd.enter_work || cmd.draw) begin
				last_ka_q <= clock_q;
			end
			if (cmd.enter_work) begin
				ka_ivl_q <= '0;
			end else if (cmd.ivl_we) begin
				ka_ivl_q <= rng_rev ? noop_min_q : noop_min_q + mod_rem;
			end
			if (cmd.draw) begin
				lfsr_q <= lfsr_nxt;
			end
			if (cmd.out_we) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			typ_q <= s_tuser;
			code_q <= s_tdata[1:0];
		end
		if (cmd.eval) begin
			r_start_q <= !d_start[TIME_W-1] && (d_start >= TIME_W'(req_timeout_q));
			r_last_q <= !d_last[TIME_W-1] && (d_last >= TIME_W'(req_interval_q));
			r_ka_q <= !d_ka[TIME_W-1] && (d_ka >= TIME_W'(ka_ivl_q));
		end
		if (cmd.out_we) begin
			m_send_q <= cmd.send;
			m_status_q <= status_q;
			m_tout_q <= cmd.tout;
		end
	end

	always_comb begin
		sts.typ = typ_q;
		sts.code = code_q;
		sts.st = status_q;
		sts.r_start = r_start_q;
		sts.r_last = r_last_q;
		sts.r_ka = r_ka_q;
		sts.mod_done = mod_done;
		sts.out_free = !m_valid_q || m_tready;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {{(OUT_DATA_W-4){1'b0}}, m_tout_q, m_status_q};
	assign m_tuser = m_send_q;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_we |-> (!m_valid_q || m_tready))
		else $error("result register overwritten while held");
	a_draw_working: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw |-> status_q == LS_WORKING)
		else $error("keep-alive draw outside working status");
	a_ivl_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ivl_we |-> mod_done)
		else $error("interval loaded without remainder");

endmodule
`default_nettype wire

@@ src/rkc_ctrl.sv @@
// controller: item sequencing and exchange decisions
`default_nettype none
module rkc_ctrl
	import rkc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire rkc_sts_t sts,
	output rkc_cmd_t      cmd
);

	fsm_state_t state_q, state_nxt;
	send_kind_t send_q, send_nxt;
	logic       tout_q, tout_nxt;
	logic       accept;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			send_q <= SEND_NONE;
			tout_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			send_q <= send_nxt;
			tout_q <= tout_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		send_nxt = send_q;
		tout_nxt = tout_q;
		s_tready = 1'b0;
		cmd = '0;
		cmd.st_nxt = sts.st;
		cmd.send = send_q;
		cmd.tout = tout_q;
		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				cmd.cap_in = accept;
				if (accept) begin
					state_nxt = FSM_LOAD;
				end
			end
			FSM_LOAD: begin
				cmd.tick_inc = sts.typ == REQ_TICK;
				send_nxt = SEND_NONE;
				tout_nxt = 1'b0;
				state_nxt = FSM_EVAL;
			end
			FSM_EVAL: begin
				cmd.eval = 1'b1;
				state_nxt = FSM_ACT;
			end
			FSM_ACT: begin
				state_nxt = FSM_OUT;
				case (sts.typ)
					REQ_TICK: begin
						if (sts.st == LS_REGING || sts.st == LS_UNREGING) begin
							if (sts.r_start) begin
								cmd.st_we = 1'b1;
								cmd.st_nxt = LS_DROPPED;
								tout_nxt = 1'b1;
							end else if (sts.r_last) begin
								cmd.last_req_we = 1'b1;
								send_nxt = (sts.st == LS_REGING) ? SEND_REGISTER
									: SEND_UNREGISTER;
							end
						end else if (sts.st == LS_WORKING && sts.r_ka) begin
							send_nxt = SEND_KEEPALIVE;
							cmd.draw = 1'b1;
							state_nxt = FSM_MODW;
						end
					end
					REQ_REGISTER: begin
						cmd.start_req = 1'b1;
						cmd.st_we = 1'b1;
						cmd.st_nxt = LS_REGING;
					end
					REQ_UNREGISTER: begin
						cmd.st_we = 1'b1;
						if (sts.st == LS_WORKING) begin
							cmd.start_req = 1'b1;
							cmd.st_nxt = LS_UNREGING;
						end else begin
							cmd.st_nxt = LS_ENDED;
						end
					end
					REQ_SEND_DATA: begin
						if (sts.st == LS_WORKING) begin
							send_nxt = SEND_DATA;
						end
					end
					REQ_REPLY: begin
						if (sts.st == LS_REGING) begin
							if (sts.code == RPL_REG_AGREE) begin
								cmd.enter_work = 1'b1;
								cmd.st_we = 1'b1;
								cmd.st_nxt = LS_WORKING;
							end else if (sts.code == RPL_REG_REFUSE) begin
								cmd.st_we = 1'b1;
								cmd.st_nxt = LS_REFUSED;
							end
						end else if (sts.st == LS_UNREGING && sts.code == RPL_UNREG_OK) begin
							cmd.st_we = 1'b1;
							cmd.st_nxt = LS_ENDED;
						end
					end
					default: ;
				endcase
			end
			FSM_MODW: begin
				if (sts.mod_done) begin
					cmd.ivl_we = 1'b1;
					state_nxt = FSM_OUT;
				end
			end
			FSM_OUT: begin
				if (sts.out_free) begin
					cmd.out_we = 1'b1;
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == FSM_LOAD)
		else $error("accepted transaction not taken into processing");
	a_draw_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw |=> state_q == FSM_MODW)
		else $error("keep-alive draw without remainder wait");
	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mod_done |-> state_q == FSM_MODW)
		else $error("remainder finished outside its wait state");

endmodule
`default_nettype wire

@@ verif/tb_registration_keepalive_client_core.sv @@
// testbench for the registration keep-alive client core: scoreboard, stream drivers and checks
`timescale 1ns / 100ps
module tb_registration_keepalive_client_core;
	import rkc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_SETTING = 200;
	localparam int SETTING_COUNT = 9;
	localparam int MAX_REPORTS = 10;
	localparam logic [CFG_W-1:0] CFG_ALL_ONES = {CFG_W{1'b1}};
	localparam logic [2:0] REQ_SPARE_A = 3'd5;
	localparam logic [2:0] REQ_SPARE_B = 3'd6;
	localparam logic [2:0] REQ_SPARE_C = 3'd7;

	typedef struct {
		send_kind_t kind;
		link_status_t st;
		logic tout;
	} link_result_t;

	class link_scoreboard;
		logic [CFG_W-1:0] req_gap, req_limit, noop_lo, noop_hi;
		link_status_t st;
		logic [TIME_W-1:0] now, req_begin, req_last, ka_last;
		logic [CFG_W-1:0] ka_gap;
		logic [LFSR_W-1:0] lfsr;
		link_result_t exp_q[$];
		int errors, requests, results, keepalives, timeouts, data_sends;

		function new();
			req_gap = REQ_INTERVAL_RST;
			req_limit = REQ_TIMEOUT_RST;
			noop_lo = NOOP_MIN_RST;
			noop_hi = NOOP_MAX_RST;
			st = LS_IDLE;
			now = '0;
			req_begin = '0;
			req_last = '0;
			ka_last = '0;
			ka_gap = '0;
			lfsr = LFSR_SEED;
			errors = 0;
			requests = 0;
			results = 0;
			keepalives = 0;
			timeouts = 0;
			data_sends = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_REQ_INTERVAL: req_gap = val;
				CFG_REQ_TIMEOUT: req_limit = val;
				CFG_NOOP_MIN: noop_lo = val;
				CFG_NOOP_MAX: noop_hi = val;
				default: ;
			endcase
		endfunction

		// negative elapsed time never reaches the threshold
		function bit elapsed_reached(logic [TIME_W-1:0] t_now, logic [TIME_W-1:0] t_then,
				logic [CFG_W-1:0] thr);
			logic [TIME_W-1:0] d;
			d = t_now - t_then;
			return !d[TIME_W-1] && (d >= thr);
		endfunction

		function void open_request(link_status_t next_st);
			st = next_st;
			req_last = now - req_gap;
			req_begin = req_last;
		endfunction

		function void note_request(logic [2:0] typ, logic [1:0] code);
			link_result_t res;
			logic lsb;
			logic [31:0] span, sum;
			res.kind = SEND_NONE;
			res.tout = 1'b0;
			case (typ)
				REQ_TICK: begin
					now = now + 1'b1;
					if (st == LS_REGING || st == LS_UNREGING) begin
						if (elapsed_reached(now, req_begin, req_limit)) begin
							st = LS_DROPPED;
							res.tout = 1'b1;
						end else if (elapsed_reached(now, req_last, req_gap)) begin
							if (st == LS_REGING)
								res.kind = SEND_REGISTER;
							else
								res.kind = SEND_UNREGISTER;
							req_last = now;
						end
					end else if (st == LS_WORKING && elapsed_reached(now, ka_last, ka_gap)) begin
						res.kind = SEND_KEEPALIVE;
						ka_last = now;
						// galois lfsr step, then pick the next interval from the range
						lsb = lfsr[0];
						lfsr = lfsr >> 1;
						if (lsb)
							lfsr = lfsr ^ LFSR_MASK;
						if (noop_hi < noop_lo) begin
							ka_gap = noop_lo;
						end else begin
							span = 32'(noop_hi) - 32'(noop_lo) + 32'd1;
							sum = 32'(noop_lo) + (32'(lfsr) % span);
							ka_gap = sum[CFG_W-1:0];
						end
					end
				end
				REQ_REGISTER: open_request(LS_REGING);
				REQ_UNREGISTER: begin
					if (st == LS_WORKING)
						open_request(LS_UNREGING);
					else
						st = LS_ENDED;
				end
				REQ_SEND_DATA: begin
					if (st == LS_WORKING)
						res.kind = SEND_DATA;
				end
				REQ_REPLY: begin
					if (st == LS_REGING) begin
						if (code == RPL_REG_AGREE) begin
							st = LS_WORKING;
							ka_last = now;
							ka_gap = '0;
						end else if (code == RPL_REG_REFUSE) begin
							st = LS_REFUSED;
						end
					end else if (st == LS_UNREGING && code == RPL_UNREG_OK) begin
						st = LS_ENDED;
					end
				end
				default: ;
			endcase
			res.st = st;
			exp_q.insert(exp_q.size(), res);
			requests++;
		endfunction

		function void check_result(logic [2:0] kind, logic [2:0] status, logic tout);
			link_result_t e;
			results++;
			if (exp_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: kind %0d status %0d timed_out %0d",
						kind, status, tout);
				return;
			end
			e = exp_q.pop_front();
			if (e.kind == SEND_KEEPALIVE)
				keepalives++;
			if (e.kind == SEND_DATA)
				data_sends++;
			if (e.tout)
				timeouts++;
			if (kind !== e.kind || status !== e.st || tout !== e.tout) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("mismatch on result %0d: expected kind %0d status %0d timed_out %0d",
						results, e.kind, e.st, e.tout);
					$display("  got kind %0d status %0d timed_out %0d",
						kind, status, tout);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;   // reply_code[1:0], zero pad
	logic [2:0] s_tuser;             // req_type[2:0]
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;  // status[2:0], timed_out[3], zero pad
	logic [2:0] m_tuser;             // send_kind[2:0]
	logic cfg_valid;
	logic cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	link_scoreboard sb;
	int ready_left = 0;
	int ready_roll;
	int burst_left = 0;
	int idle_cycles = 0;
	int settings_used = 0;

	registration_keepalive_client_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (ready_left > 0) begin
			ready_left--;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 45) begin
				m_tready = 1'b1;
				ready_left = $urandom_range(0, 6);
			end else if (ready_roll < 60) begin
				m_tready = 1'b1;
				ready_left = $urandom_range(20, 80);
			end else if (ready_roll < 95) begin
				m_tready = 1'b0;
				ready_left = $urandom_range(0, 3);
			end else begin
				m_tready = 1'b0;
				ready_left = $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[1:0]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata[2:0], m_tdata[3]);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				idle_cycles, sb.exp_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	function int sender_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			burst_left = $urandom_range(20, 50);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_item(logic [2:0] typ, logic [1:0] code);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = typ;
		s_tdata = {{(IN_DATA_W-2){1'b0}}, code};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.exp_q.size() != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic apply_setting(int ph);
		logic [CFG_W-1:0] ivl, tmo, lo, hi;
		case (ph)
			0: begin
				// resend every tick, keep-alive every tick, never drop
				ivl = '0;
				tmo = CFG_ALL_ONES;
				lo = '0;
				hi = '0;
			end
			1: begin
				// first tick drops, reversed keep-alive range
				ivl = CFG_ALL_ONES;
				tmo = CFG_ALL_ONES;
				lo = CFG_ALL_ONES;
				hi = '0;
			end
			2: begin
				ivl = CFG_W'($urandom_range(0, CFG_ALL_ONES));
				tmo = CFG_W'($urandom_range(0, CFG_ALL_ONES));
				lo = CFG_W'($urandom_range(0, CFG_ALL_ONES));
				hi = CFG_W'($urandom_range(0, CFG_ALL_ONES));
			end
			default: begin
				ivl = CFG_W'($urandom_range(0, 6));
				tmo = CFG_W'($urandom_range(4, 30));
				lo = CFG_W'($urandom_range(0, 8));
				hi = CFG_W'($urandom_range(0, 20));
			end
		endcase
		write_reg(CFG_REQ_INTERVAL, ivl);
		write_reg(CFG_REQ_TIMEOUT, tmo);
		write_reg(CFG_NOOP_MIN, lo);
		write_reg(CFG_NOOP_MAX, hi);
		settings_used++;
	endtask

	// mostly well-formed exchanges steered by the predicted status, some noise
	task automatic next_random_item(output logic [2:0] typ, output logic [1:0] code);
		int r;
		r = $urandom_range(0, 99);
		code = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 12) begin
			typ = 3'($urandom_range(0, 7));
			return;
		end
		case (sb.st)
			LS_REGING: begin
				if (r < 88) begin
					typ = REQ_TICK;
				end else begin
					typ = REQ_REPLY;
					if (r < 94)
						code = RPL_REG_AGREE;
					else if (r < 97)
						code = RPL_REG_REFUSE;
				end
			end
			LS_WORKING: begin
				if (r < 65)
					typ = REQ_TICK;
				else if (r < 82)
					typ = REQ_SEND_DATA;
				else if (r < 90)
					typ = REQ_UNREGISTER;
				else if (r < 95)
					typ = REQ_REGISTER;
				else
					typ = REQ_REPLY;
			end
			LS_UNREGING: begin
				if (r < 78) begin
					typ = REQ_TICK;
				end else begin
					typ = REQ_REPLY;
					if (r < 92)
						code = RPL_UNREG_OK;
				end
			end
			default: begin
				if (r < 55)
					typ = REQ_REGISTER;
				else
					typ = REQ_TICK;
			end
		endcase
	endtask

	initial begin
		logic [2:0] typ;
		logic [1:0] code;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_TICK;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_REQ_INTERVAL;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed walk through every request and reply at reset settings
		send_item(REQ_TICK, RPL_OTHER);
		send_item(REQ_SEND_DATA, RPL_REG_AGREE);
		send_item(REQ_REPLY, RPL_REG_AGREE);
		send_item(REQ_SPARE_A, RPL_REG_REFUSE);
		send_item(REQ_SPARE_B, RPL_UNREG_OK);
		send_item(REQ_SPARE_C, RPL_OTHER);
		send_item(REQ_UNREGISTER, RPL_REG_AGREE);
		send_item(REQ_REGISTER, RPL_OTHER);
		send_item(REQ_TICK, RPL_REG_AGREE);
		send_item(REQ_REPLY, RPL_OTHER);
		send_item(REQ_REPLY, RPL_UNREG_OK);
		send_item(REQ_REPLY, RPL_REG_AGREE);
		send_item(REQ_TICK, RPL_REG_REFUSE);
		send_item(REQ_TICK, RPL_OTHER);
		send_item(REQ_SEND_DATA, RPL_OTHER);
		send_item(REQ_REGISTER, RPL_REG_AGREE);
		send_item(REQ_REPLY, RPL_REG_REFUSE);
		send_item(REQ_REGISTER, RPL_UNREG_OK);
		send_item(REQ_REPLY, RPL_REG_AGREE);
		send_item(REQ_UNREGISTER, RPL_OTHER);
		send_item(REQ_TICK, RPL_REG_AGREE);
		send_item(REQ_REPLY, RPL_REG_AGREE);
		send_item(REQ_REPLY, RPL_UNREG_OK);
		send_item(REQ_REPLY, RPL_OTHER);

		for (int ph = 0; ph < SETTING_COUNT; ph++) begin
			settle();
			apply_setting(ph);
			for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
				next_random_item(typ, code);
				send_item(typ, code);
			end
		end
		settle();

		$display("run: %0d requests under %0d register settings, %0d results checked",
			sb.requests, settings_used + 1, sb.results);
		$display("run: %0d keep-alives, %0d data sends, %0d timeouts, %0d mismatches",
			sb.keepalives, sb.data_sends, sb.timeouts, sb.errors);
		if (sb.errors == 0 && sb.exp_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
